>>> rtl/core/prt_pkg.sv
// Shared constants and types for the point rotation pipeline.
// No dependencies.
package prt_pkg;

  // Extra fraction bits carried through the CORDIC datapath.
  localparam int GUARD = 8;

  // Angle accumulator width: 2^32 per full turn plus a sign bit.
  localparam int ZW = 33;

  // CORDIC limit gain 0.6072529350 as an unsigned 0.32 fraction.
  localparam logic [31:0] KGAIN = 32'd2608131496;

  // atan(2^-i) / (2*pi) * 2^32, truncated.
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
  };

  // Control that travels with each item down the pipeline.
  typedef struct packed {
    logic valid;  // stage holds a live item
    logic same;   // point equals pivot: pass pivot through unchanged
  } ctl_t;

endpackage

>>> rtl/core/prt_prep.sv
// Input stage: pivot offset, quarter-turn pre-rotation and residual angle.
// Depends on prt_pkg.
module prt_prep #(
  parameter int CB = 32,
  parameter int AB = 16,
  parameter int W  = 43
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [CB-1:0]    point_x,
  input  logic signed [CB-1:0]    point_y,
  input  logic signed [CB-1:0]    pivot_x,
  input  logic signed [CB-1:0]    pivot_y,
  input  logic [AB-1:0]           turn_angle,
  output logic signed [W-1:0]     x,
  output logic signed [W-1:0]     y,
  output logic signed [prt_pkg::ZW-1:0] z,
  output logic signed [CB-1:0]    piv_x,
  output logic signed [CB-1:0]    piv_y,
  output prt_pkg::ctl_t           ctl
);
  import prt_pkg::*;

  logic signed [CB:0]   dx, dy, rot_x, rot_y;
  logic [AB-1:0]        q_sum, resid;
  logic [1:0]           quad;
  logic signed [W-1:0]  x_next, y_next;
  logic signed [ZW-1:0] z_next;

  always_comb begin
    dx    = {point_x[CB-1], point_x} - {pivot_x[CB-1], pivot_x};
    dy    = {point_y[CB-1], point_y} - {pivot_y[CB-1], pivot_y};
    // Nearest quarter turn, leaving the residual in [-1/8, 1/8) turn.
    q_sum = turn_angle + {3'b001, {(AB-3){1'b0}}};
    quad  = q_sum[AB-1:AB-2];
    resid = turn_angle - {quad, {(AB-2){1'b0}}};
    z_next = {{(ZW-AB){resid[AB-1]}}, resid} <<< (32 - AB);
    case (quad)
      2'd0: begin
        rot_x = dx;
        rot_y = dy;
      end
      2'd1: begin
        rot_x = -dy;
        rot_y = dx;
      end
      2'd2: begin
        rot_x = -dx;
        rot_y = -dy;
      end
      2'd3: begin
        rot_x = dy;
        rot_y = -dx;
      end
      default: begin
        rot_x = dx;
        rot_y = dy;
      end
    endcase
    x_next = W'(rot_x) <<< GUARD;
    y_next = W'(rot_y) <<< GUARD;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl.valid <= start;
      ctl.same  <= (point_x == pivot_x) && (point_y == pivot_y);
    end
  end

  always_ff @(posedge clk) begin
    x     <= x_next;
    y     <= y_next;
    z     <= z_next;
    piv_x <= pivot_x;
    piv_y <= pivot_y;
  end

endmodule

>>> rtl/core/prt_stage.sv
// One registered CORDIC rotation-mode micro-rotation.
// Depends on prt_pkg.
module prt_stage #(
  parameter int CB    = 32,
  parameter int W     = 43,
  parameter int SHIFT = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic signed [W-1:0]           x_in,
  input  logic signed [W-1:0]           y_in,
  input  logic signed [prt_pkg::ZW-1:0] z_in,
  input  logic signed [CB-1:0]          piv_x_in,
  input  logic signed [CB-1:0]          piv_y_in,
  input  prt_pkg::ctl_t                 ctl_in,
  output logic signed [W-1:0]           x_out,
  output logic signed [W-1:0]           y_out,
  output logic signed [prt_pkg::ZW-1:0] z_out,
  output logic signed [CB-1:0]          piv_x_out,
  output logic signed [CB-1:0]          piv_y_out,
  output prt_pkg::ctl_t                 ctl_out
);
  import prt_pkg::*;

  localparam logic signed [ZW-1:0] ATAN = ZW'(ATAN_TAB[SHIFT]);

  logic signed [W-1:0]  xs, ys, x_next, y_next;
  logic signed [ZW-1:0] z_next;

  always_comb begin
    xs = x_in >>> SHIFT;
    ys = y_in >>> SHIFT;
    // Turn counterclockwise while the remaining angle is non-negative.
    if (!z_in[ZW-1]) begin
      x_next = x_in - ys;
      y_next = y_in + xs;
      z_next = z_in - ATAN;
    end else begin
      x_next = x_in + ys;
      y_next = y_in - xs;
      z_next = z_in + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    x_out     <= x_next;
    y_out     <= y_next;
    z_out     <= z_next;
    piv_x_out <= piv_x_in;
    piv_y_out <= piv_y_in;
  end

endmodule

>>> rtl/core/prt_gain.sv
// Gain removal, rounding, pivot add-back and saturation, five register stages.
// Depends on prt_pkg.
module prt_gain #(
  parameter int CB = 32,
  parameter int W  = 43
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic signed [W-1:0]  x_in,
  input  logic signed [W-1:0]  y_in,
  input  logic signed [CB-1:0] piv_x_in,
  input  logic signed [CB-1:0] piv_y_in,
  input  prt_pkg::ctl_t        ctl_in,
  output logic                 done,
  output logic signed [CB-1:0] rotated_x,
  output logic signed [CB-1:0] rotated_y,
  output logic                 saturated
);
  import prt_pkg::*;

  localparam int MW = (W > 32) ? W : 33;       // magnitude, padded above 32 bits
  localparam int HW = MW - 32;                 // upper magnitude slice
  localparam int PW = HW + 33;                 // product scaled by 2^-32
  localparam int VW = HW + 27;                 // signed result after guard removal
  localparam int SW = ((VW > CB) ? VW : CB) + 2;

  // Pipeline control and pivot for stages 1 to 4; stage 5 is the output register.
  ctl_t                ctl   [4];
  logic signed [CB-1:0] pvx  [4];
  logic signed [CB-1:0] pvy  [4];

  logic [1:0]           sat_lane;
  logic signed [CB-1:0] out_lane [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < 4; s++) begin
        ctl[s] <= '0;
      end
    end else begin
      ctl[0] <= ctl_in;
      for (int s = 1; s < 4; s++) begin
        ctl[s] <= ctl[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    pvx[0] <= piv_x_in;
    pvy[0] <= piv_y_in;
    for (int s = 1; s < 4; s++) begin
      pvx[s] <= pvx[s-1];
      pvy[s] <= pvy[s-1];
    end
  end

  for (genvar c = 0; c < 2; c++) begin : g_lane
    logic signed [W-1:0]  v_in;
    logic signed [CB-1:0] piv;
    logic [W-1:0]         mag_next;
    logic [MW-1:0]        mag;
    logic                 neg1, neg2, neg3;
    logic [63:0]          lo_k;
    logic [PW-2:0]        hi_k;
    logic [PW-1:0]        p0, p0_next;
    logic [PW:0]          p0_rnd;
    logic [VW-2:0]        p1;
    logic signed [VW-1:0] v, v_next;
    logic signed [SW-1:0] sum;
    logic                 fits;
    logic signed [CB-1:0] clip_val;
    logic [64:0]          lo_rnd;

    assign v_in = (c == 0) ? x_in : y_in;
    assign piv  = (c == 0) ? pvx[3] : pvy[3];

    always_comb begin
      mag_next = v_in[W-1] ? (~v_in + W'(1)) : v_in;
      lo_rnd   = {1'b0, lo_k} + 65'h0_8000_0000;
      p0_next  = PW'(hi_k) + PW'(lo_rnd[64:32]);
      p0_rnd   = {1'b0, p0} + (PW+1)'(1 << (GUARD - 1));
      p1       = p0_rnd[PW:GUARD];
      v_next   = neg3 ? -$signed({1'b0, p1}) : $signed({1'b0, p1});
      sum      = SW'(v) + SW'(piv);
      fits     = (sum[SW-1:CB-1] == '0) || (sum[SW-1:CB-1] == '1);
      if (fits) begin
        clip_val = sum[CB-1:0];
      end else if (sum[SW-1]) begin
        clip_val = {1'b1, {(CB-1){1'b0}}};
      end else begin
        clip_val = {1'b0, {(CB-1){1'b1}}};
      end
    end

    always_ff @(posedge clk) begin
      // Stage 1: sign and magnitude.
      mag  <= MW'(mag_next);
      neg1 <= v_in[W-1];
      // Stage 2: split product, each part within 32 x 32.
      lo_k <= mag[31:0] * KGAIN;
      hi_k <= mag[MW-1:32] * KGAIN;
      neg2 <= neg1;
      // Stage 3: combine parts, rounding the low half.
      p0   <= p0_next;
      neg3 <= neg2;
      // Stage 4: drop guard bits with rounding, restore sign.
      v    <= v_next;
    end

    assign sat_lane[c] = !fits;
    assign out_lane[c] = clip_val;
  end

  // Stage 5: add pivot, clip; a point on the pivot passes through.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl[3].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl[3].same) begin
      rotated_x <= pvx[3];
      rotated_y <= pvy[3];
      saturated <= 1'b0;
    end else begin
      rotated_x <= out_lane[0];
      rotated_y <= out_lane[1];
      saturated <= |sat_lane;
    end
  end

endmodule

>>> rtl/core/point_rotate_about_origin.sv
// Rotates a point about a pivot by a binary angle with a pipelined CORDIC.
// Registers from start to done: one input stage, one register per micro-rotation,
// five for gain and clipping.
// Throughput: one transfer every cycle outside reset; the unrolled stages hold one item each.
// Reset (rst, synchronous) clears every valid bit; busy is high only during reset.
// Results appear for one cycle under done and cannot be held off.
// Depends on prt_pkg, prt_prep, prt_stage and prt_gain.
module point_rotate_about_origin #(
  parameter int COORD_BITS    = 32,
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] pivot_x,
  input  logic signed [COORD_BITS-1:0] pivot_y,
  input  logic [ANGLE_BITS-1:0]        turn_angle,
  output logic                         done,
  output logic signed [COORD_BITS-1:0] rotated_x,
  output logic signed [COORD_BITS-1:0] rotated_y,
  output logic                         saturated
);
  import prt_pkg::*;

  // Datapath width: offset (COORD_BITS+1), guard fraction, and two bits of
  // headroom for the pre-rotation magnitude times the CORDIC gain.
  localparam int W = COORD_BITS + GUARD + 3;

  // Per-stage pipeline buses; entry 0 comes from the input stage.
  logic signed [W-1:0]          x_p   [CORDIC_STAGES+1];
  logic signed [W-1:0]          y_p   [CORDIC_STAGES+1];
  logic signed [ZW-1:0]         z_p   [CORDIC_STAGES+1];
  logic signed [COORD_BITS-1:0] pvx_p [CORDIC_STAGES+1];
  logic signed [COORD_BITS-1:0] pvy_p [CORDIC_STAGES+1];
  ctl_t                         ctl_p [CORDIC_STAGES+1];

  // Nothing ever stalls; hold off transfers only while reset is applied.
  assign busy = rst;

  // Take the offset from the pivot and turn it by whole quarter turns.
  prt_prep #(
    .CB (COORD_BITS),
    .AB (ANGLE_BITS),
    .W  (W)
  ) u_prep (
    .clk        (clk),
    .rst        (rst),
    .start      (start && !busy),
    .point_x    (point_x),
    .point_y    (point_y),
    .pivot_x    (pivot_x),
    .pivot_y    (pivot_y),
    .turn_angle (turn_angle),
    .x          (x_p[0]),
    .y          (y_p[0]),
    .z          (z_p[0]),
    .piv_x      (pvx_p[0]),
    .piv_y      (pvy_p[0]),
    .ctl        (ctl_p[0])
  );

  // Unrolled micro-rotations, one register stage each.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    prt_stage #(
      .CB    (COORD_BITS),
      .W     (W),
      .SHIFT (i)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .x_in      (x_p[i]),
      .y_in      (y_p[i]),
      .z_in      (z_p[i]),
      .piv_x_in  (pvx_p[i]),
      .piv_y_in  (pvy_p[i]),
      .ctl_in    (ctl_p[i]),
      .x_out     (x_p[i+1]),
      .y_out     (y_p[i+1]),
      .z_out     (z_p[i+1]),
      .piv_x_out (pvx_p[i+1]),
      .piv_y_out (pvy_p[i+1]),
      .ctl_out   (ctl_p[i+1])
    );
  end

  // Remove the CORDIC gain, add the pivot back and clip to range.
  prt_gain #(
    .CB (COORD_BITS),
    .W  (W)
  ) u_gain (
    .clk       (clk),
    .rst       (rst),
    .x_in      (x_p[CORDIC_STAGES]),
    .y_in      (y_p[CORDIC_STAGES]),
    .piv_x_in  (pvx_p[CORDIC_STAGES]),
    .piv_y_in  (pvy_p[CORDIC_STAGES]),
    .ctl_in    (ctl_p[CORDIC_STAGES]),
    .done      (done),
    .rotated_x (rotated_x),
    .rotated_y (rotated_y),
    .saturated (saturated)
  );

endmodule

>>> tb/point_rotate_about_origin_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for point_rotate_about_origin: drives point/pivot/angle transfers
// and checks each result against a bit-exact CORDIC predictor. Depends on prt_pkg.
module point_rotate_about_origin_tb;
  import prt_pkg::*;

  localparam int COORD_BITS    = 32;
  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;
  // Pipeline depth from start to done, plus margin for the final settle.
  localparam int PIPE_DEPTH    = CORDIC_STAGES + 6;
  localparam int SETTLE_CYCLES = PIPE_DEPTH + 16;
  localparam int RANDOM_POINTS = 1300;

  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [COORD_BITS-1:0] ONE       = 32'sd65536;  // 1.0 in Q16.16

  typedef struct {
    logic signed [COORD_BITS-1:0] px, py, cx, cy;
    logic [ANGLE_BITS-1:0]        angle;
    int unsigned                  gap;    // idle cycles before this transfer
    bit                           drain;  // hold until all earlier results are back
  } point_req_t;

  typedef struct {
    logic signed [COORD_BITS-1:0] x, y;
    logic                         sat;
  } rotation_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [COORD_BITS-1:0] point_x = '0, point_y = '0, pivot_x = '0, pivot_y = '0;
  logic [ANGLE_BITS-1:0] turn_angle = '0;
  logic done;
  logic signed [COORD_BITS-1:0] rotated_x, rotated_y;
  logic saturated;

  // Outputs captured mid-cycle, so the clocked blocks never race the block's registers.
  logic busy_s, done_s, sat_s;
  logic signed [COORD_BITS-1:0] rx_s, ry_s;

  point_req_t  pending_points[$];
  rotation_t   expected_rotations[$];
  point_req_t  on_ports;
  int unsigned idle_left = 0;
  int unsigned accepted_cnt = 0;
  int unsigned total_points = 0;
  int unsigned errors = 0;
  bit          no_idle_run = 1'b0;

  point_rotate_about_origin #(
    .COORD_BITS   (COORD_BITS),
    .ANGLE_BITS   (ANGLE_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .point_x   (point_x),
    .point_y   (point_y),
    .pivot_x   (pivot_x),
    .pivot_y   (pivot_y),
    .turn_angle(turn_angle),
    .done      (done),
    .rotated_x (rotated_x),
    .rotated_y (rotated_y),
    .saturated (saturated)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Multiply by the limit gain and drop the guard bits; the magnitude is rounded
  // half away from zero once at the guard position and once at the integer LSB.
  function automatic longint remove_cordic_gain(longint v);
    logic [63:0] mag, hi, lo, prod;
    bit neg;
    neg  = v < 0;
    mag  = neg ? 64'(-v) : 64'(v);
    hi   = mag >> 32;
    lo   = mag & 64'hFFFF_FFFF;
    prod = hi * 64'(KGAIN) + ((lo * 64'(KGAIN) + 64'h8000_0000) >> 32);
    prod = (prod + (64'd1 << (GUARD - 1))) >> GUARD;
    return neg ? -longint'(prod) : longint'(prod);
  endfunction

  // Clip to the signed coordinate range and flag the clip.
  function automatic logic signed [COORD_BITS-1:0] clamp_coord(longint v, inout logic sat);
    if (v > longint'(COORD_MAX)) begin
      sat = 1'b1;
      return COORD_MAX;
    end
    if (v < longint'(COORD_MIN)) begin
      sat = 1'b1;
      return COORD_MIN;
    end
    return v[COORD_BITS-1:0];
  endfunction

  // Expected result of one transfer: quarter-turn pre-rotation, CORDIC in rotation
  // mode on the residual angle, gain removal, pivot add-back and saturation.
  function automatic rotation_t rotate_about_pivot(point_req_t r);
    rotation_t res;
    longint x, y, z, t, xs, ys;
    int unsigned quad;
    logic [ANGLE_BITS-1:0] qoff, resid;
    res.sat = 1'b0;
    if (r.px == r.cx && r.py == r.cy) begin
      res.x = r.px;
      res.y = r.py;
      return res;
    end
    x = longint'(r.px) - longint'(r.cx);
    y = longint'(r.py) - longint'(r.cy);
    // Pick the quarter turn that leaves the residual in [-1/8, 1/8) turn.
    quad  = ((int'(r.angle) + (1 << (ANGLE_BITS - 3))) >> (ANGLE_BITS - 2)) & 3;
    qoff  = ANGLE_BITS'(quad << (ANGLE_BITS - 2));
    resid = r.angle - qoff;
    z = longint'($signed(resid)) * (longint'(1) << (32 - ANGLE_BITS));
    for (int k = 0; k < quad; k++) begin
      t = x;
      x = -y;
      y = t;
    end
    x = x * (longint'(1) << GUARD);
    y = y * (longint'(1) << GUARD);
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ATAN_TAB[i]);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ATAN_TAB[i]);
      end
    end
    res.x = clamp_coord(remove_cordic_gain(x) + longint'(r.cx), res.sat);
    res.y = clamp_coord(remove_cordic_gain(y) + longint'(r.cy), res.sat);
    return res;
  endfunction

  // Append one point with an idle gap drawn from the current idling mode:
  // mostly back-to-back, some short gaps, a few long ones.
  task automatic queue_point(input logic signed [COORD_BITS-1:0] px, py, cx, cy,
                             input logic [ANGLE_BITS-1:0] angle, input bit drain);
    point_req_t r;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    r.px = px;
    r.py = py;
    r.cx = cx;
    r.cy = cy;
    r.angle = angle;
    r.drain = drain;
    if (no_idle_run || sel < 65) r.gap = 0;
    else if (sel < 92) r.gap = $urandom_range(1, 3);
    else r.gap = $urandom_range(8, 40);
    pending_points.push_back(r);
    total_points++;
  endtask

  function automatic logic signed [COORD_BITS-1:0] corner_coord();
    case ($urandom_range(0, 5))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return '0;
      3: return -1;
      4: return 1;
      default: return $urandom;
    endcase
  endfunction

  // Capture outputs on the falling edge; the clocked blocks below use these copies.
  always @(negedge clk) begin
    busy_s <= busy;
    done_s <= done;
    rx_s   <= rotated_x;
    ry_s   <= rotated_y;
    sat_s  <= saturated;
  end

  // Driver: record the transfer that completes at this edge, then either hold
  // the item, idle out the gap, wait for a drain, or present the next point.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy_s) begin
        expected_rotations.push_back(rotate_about_pivot(on_ports));
        accepted_cnt++;
      end
      if (start && busy_s) begin
        // hold the item until the block takes it
      end else if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (pending_points.size() != 0 &&
                   !(pending_points[0].drain && expected_rotations.size() != 0)) begin
        on_ports = pending_points.pop_front();
        point_x    <= on_ports.px;
        point_y    <= on_ports.py;
        pivot_x    <= on_ports.cx;
        pivot_y    <= on_ports.cy;
        turn_angle <= on_ports.angle;
        start      <= 1'b1;
        if (pending_points.size() != 0) idle_left = pending_points[0].gap;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every done cycle is one result transfer; compare it with the oldest prediction.
  always @(posedge clk) begin : check_results
    rotation_t want;
    if (!rst && done_s === 1'b1) begin
      if (expected_rotations.size() == 0) begin
        $error("unexpected result: rotated_x=%0d rotated_y=%0d saturated=%0b",
               rx_s, ry_s, sat_s);
        errors++;
      end else begin
        want = expected_rotations.pop_front();
        if (rx_s !== want.x) begin
          $error("rotated_x: expected %0d, got %0d", want.x, rx_s);
          errors++;
        end
        if (ry_s !== want.y) begin
          $error("rotated_y: expected %0d, got %0d", want.y, ry_s);
          errors++;
        end
        if (sat_s !== want.sat) begin
          $error("saturated: expected %0b, got %0b", want.sat, sat_s);
          errors++;
        end
      end
    end
  end

  initial begin
    logic signed [COORD_BITS-1:0] px, py, cx, cy;
    logic [ANGLE_BITS-1:0] ang;
    int unsigned kind;

    // Directed: point on pivot, quadrant boundaries, residual edges, full-range offsets.
    queue_point('0, '0, '0, '0, '0, 1'b0);
    queue_point(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 16'd12345, 1'b0);
    queue_point(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 16'hFFFF, 1'b0);
    queue_point(1, '0, '0, '0, '0, 1'b0);
    queue_point(ONE, '0, '0, '0, 16'd16384, 1'b0);
    queue_point(ONE, '0, '0, '0, 16'd32768, 1'b0);
    queue_point(ONE, '0, '0, '0, 16'd49152, 1'b0);
    queue_point(ONE, '0, '0, '0, 16'd8192, 1'b0);
    queue_point(ONE, '0, '0, '0, 16'd8191, 1'b0);
    queue_point(ONE, '0, '0, '0, 16'd57344, 1'b0);
    queue_point(ONE, '0, '0, '0, 16'd57343, 1'b0);
    queue_point(ONE, '0, '0, '0, 16'hFFFF, 1'b0);
    queue_point(ONE, ONE, -ONE, ONE, 16'd24576, 1'b0);
    queue_point('0, -3 * ONE, 5 * ONE, 7 * ONE, 16'd24575, 1'b0);
    queue_point(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, '0, 1'b0);
    queue_point(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 16'd32768, 1'b0);
    queue_point(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 16'd8192, 1'b0);
    queue_point(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 16'd40960, 1'b0);
    queue_point(COORD_MAX, '0, '0, '0, 16'd8192, 1'b0);
    queue_point(COORD_MIN, COORD_MIN, '0, '0, 16'd24576, 1'b0);
    queue_point(32'sd123456, -32'sd654321, 32'sd123456, 32'sd777, 16'd4096, 1'b0);
    queue_point(-1, -1, '0, '0, 16'd43690, 1'b0);
    queue_point(COORD_MAX, COORD_MAX, '0, '0, '0, 1'b0);

    // Random: mixed shapes, with runs of back-to-back transfers and occasional drains.
    for (int n = 0; n < RANDOM_POINTS; n++) begin
      if (n % 50 == 0) no_idle_run = ($urandom_range(0, 2) == 0);
      kind = $urandom_range(0, 99);
      cx  = $urandom;
      cy  = $urandom;
      px  = $urandom;
      py  = $urandom;
      ang = ANGLE_BITS'($urandom);
      if (kind < 45) begin
        // full-range coordinates as drawn
      end else if (kind < 70) begin
        // small offset around a random pivot
        px = cx + (int'($urandom) >>> $urandom_range(7, 31));
        py = cy + (int'($urandom) >>> $urandom_range(7, 31));
      end else if (kind < 80) begin
        px = cx;
        py = cy;
      end else if (kind < 90) begin
        px = corner_coord();
        py = corner_coord();
        cx = corner_coord();
        cy = corner_coord();
      end else begin
        // angle right on or next to a multiple of 1/8 turn
        ang = ANGLE_BITS'(($urandom_range(0, 7) << (ANGLE_BITS - 3)) +
                          $urandom_range(0, 2) - 1);
      end
      queue_point(px, py, cx, cy, ang, n == 0 || $urandom_range(0, 99) == 0);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (accepted_cnt != total_points) @(posedge clk);
    while (expected_rotations.size() != 0) @(posedge clk);
    // Let any stray result surface before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("point_rotate_about_origin: match");
    end else begin
      $display("point_rotate_about_origin: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("point_rotate_about_origin: mismatch");
    $finish;
  end

endmodule
